// ----- hw/rtl/gwch_pkg.sv -----
// Shared package for the gift-wrapping convex hull block.
// Holds field widths, parameter defaults and the controller/datapath
// command and status structs. No dependencies.
package gwch_pkg;

  localparam int FIELD_W        = 16;
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  typedef struct packed {
    logic store;
    logic scan_init;
    logic scan_cmp;
    logic walk_init;
    logic rd_q;
    logic q_load;
    logic pt_diff;
    logic pt_mul;
    logic pt_cmp;
    logic advance;
    logic finish;
  } gwch_cmd_t;

  typedef struct packed {
    logic i_last;
    logic vtx_last;
  } gwch_stat_t;

endpackage

// ----- hw/rtl/gift_wrapping_convex_hull.sv -----
// Gift-wrapping convex hull: top level joining controller and datapath.
// Depends on gwch_pkg, gwch_ctrl and gwch_dp.
//
// Usage:
//   Point channel (pt_valid / pt_stall, point_x, point_y, last_point):
//   one point transfers per cycle while loading. Points beyond MAX_POINTS
//   are dropped and flag points_dropped on every vertex of that set.
//   The transfer with last_point high ends the set; pt_stall then stays
//   high until the final vertex has transferred.
//   Hull channel (hull_valid / hull_stall, hull_x, hull_y, last_vertex,
//   points_dropped, walk_cut_short): vertices in clockwise order from the
//   leftmost point; last_vertex marks the final one, walk_cut_short marks
//   a walk that hit MAX_POINTS vertices without closing.
//   The leftmost scan reads each stored point once; each vertex then
//   scans every stored point as a candidate, paced by the single memory read
//   port and the difference, multiply and compare steps per candidate.
//   A stalled vertex holds its fields and the walk waits.
//   Reset (rst, synchronous) empties the point set and returns to loading.
module gift_wrapping_convex_hull #(
  parameter int MAX_POINTS = gwch_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = gwch_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pt_valid,
  output logic                               pt_stall,
  input  logic signed [gwch_pkg::FIELD_W-1:0] point_x,
  input  logic signed [gwch_pkg::FIELD_W-1:0] point_y,
  input  logic                               last_point,
  output logic                               hull_valid,
  input  logic                               hull_stall,
  output logic signed [gwch_pkg::FIELD_W-1:0] hull_x,
  output logic signed [gwch_pkg::FIELD_W-1:0] hull_y,
  output logic                               last_vertex,
  output logic                               points_dropped,
  output logic                               walk_cut_short
);
  import gwch_pkg::*;

  gwch_cmd_t  cmd;
  gwch_stat_t stat;

  gwch_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pt_valid   (pt_valid),
    .last_point (last_point),
    .hull_stall (hull_stall),
    .stat       (stat),
    .pt_stall   (pt_stall),
    .hull_valid (hull_valid),
    .cmd        (cmd)
  );

  gwch_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .point_x        (point_x),
    .point_y        (point_y),
    .stat           (stat),
    .hull_x         (hull_x),
    .hull_y         (hull_y),
    .last_vertex    (last_vertex),
    .points_dropped (points_dropped),
    .walk_cut_short (walk_cut_short)
  );

endmodule

// ----- hw/rtl/gwch_ctrl.sv -----
// Sequencer for the hull block: loading, leftmost-point scan, hull walk.
// Drives the datapath through gwch_cmd_t and reads back gwch_stat_t.
// Depends on gwch_pkg.
module gwch_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pt_valid,
  input  logic                last_point,
  input  logic                hull_stall,
  input  gwch_pkg::gwch_stat_t stat,
  output logic                pt_stall,
  output logic                hull_valid,
  output gwch_pkg::gwch_cmd_t  cmd
);
  import gwch_pkg::*;

  typedef enum logic [3:0] {
    LOAD, SCAN_RD, SCAN_CMP, WALK_INIT, Q_RD, Q_LD,
    PT_RD, PT_DIFF, PT_MUL, PT_CMP, EMIT
  } state_t;

  state_t state;

  logic pt_xfer;
  logic hull_xfer;

  assign pt_stall   = (state != LOAD);
  assign hull_valid = (state == EMIT);
  assign pt_xfer    = pt_valid && (state == LOAD);
  assign hull_xfer  = (state == EMIT) && !hull_stall;

  always_comb begin
    cmd           = '0;
    cmd.store     = pt_xfer;
    cmd.scan_init = pt_xfer && last_point;
    cmd.scan_cmp  = (state == SCAN_CMP);
    cmd.walk_init = (state == WALK_INIT);
    cmd.rd_q      = (state == Q_RD);
    cmd.q_load    = (state == Q_LD);
    cmd.pt_diff   = (state == PT_DIFF);
    cmd.pt_mul    = (state == PT_MUL);
    cmd.pt_cmp    = (state == PT_CMP);
    cmd.advance   = hull_xfer && !stat.vtx_last;
    cmd.finish    = hull_xfer && stat.vtx_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
    end else begin
      case (state)
        LOAD: begin
          if (pt_xfer && last_point) state <= SCAN_RD;
        end
        SCAN_RD:   state <= SCAN_CMP;
        SCAN_CMP: begin
          state <= stat.i_last ? WALK_INIT : SCAN_RD;
        end
        WALK_INIT: state <= Q_RD;
        Q_RD:      state <= Q_LD;
        Q_LD:      state <= PT_RD;
        PT_RD:     state <= PT_DIFF;
        PT_DIFF:   state <= PT_MUL;
        PT_MUL:    state <= PT_CMP;
        PT_CMP: begin
          state <= stat.i_last ? EMIT : PT_RD;
        end
        EMIT: begin
          if (hull_xfer) state <= stat.vtx_last ? LOAD : Q_RD;
        end
        default:   state <= LOAD;
      endcase
    end
  end

endmodule

// ----- hw/rtl/gwch_dp.sv -----
// Datapath for the hull block: point memory, scan and walk registers,
// difference, cross-product and compare stages, result fields.
// Depends on gwch_pkg.
module gwch_dp #(
  parameter int MAX_POINTS = gwch_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = gwch_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gwch_pkg::gwch_cmd_t                  cmd,
  input  logic signed [gwch_pkg::FIELD_W-1:0]  point_x,
  input  logic signed [gwch_pkg::FIELD_W-1:0]  point_y,
  output gwch_pkg::gwch_stat_t                 stat,
  output logic signed [gwch_pkg::FIELD_W-1:0]  hull_x,
  output logic signed [gwch_pkg::FIELD_W-1:0]  hull_y,
  output logic                                last_vertex,
  output logic                                points_dropped,
  output logic                                walk_cut_short
);
  import gwch_pkg::*;

  localparam int KEEP  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int DW    = KEEP + 1;
  localparam int PW    = 2 * DW;
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic signed [KEEP-1:0] mem_x [MAX_POINTS];
  logic signed [KEEP-1:0] mem_y [MAX_POINTS];

  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [CNT_W-1:0] emitted;

  logic [IW-1:0] i;
  logic [IW-1:0] start;
  logic [IW-1:0] p;
  logic [IW-1:0] q;
  logic [IW-1:0] q0;
  logic [IW-1:0] rd_addr;

  logic signed [KEEP-1:0] rd_x, rd_y;
  logic signed [KEEP-1:0] sx, sy;
  logic signed [KEEP-1:0] px, py;
  logic signed [KEEP-1:0] qx, qy;
  logic signed [KEEP-1:0] ix, iy;
  logic signed [DW-1:0]   dqx, dqy;
  logic signed [DW-1:0]   dix, diy;
  logic signed [PW-1:0]   prod_a, prod_b;

  logic [CNT_W-1:0] p_inc;
  logic             closing;

  assign p_inc   = CNT_W'(p) + CNT_W'(1);
  assign q0      = (p_inc == count) ? '0 : p_inc[IW-1:0];
  assign rd_addr = cmd.rd_q ? q0 : i;

  assign closing       = (q == start);
  assign stat.i_last   = (CNT_W'(i) == count - CNT_W'(1));
  assign stat.vtx_last = closing || (emitted == CNT_W'(MAX_POINTS - 1));

  assign hull_x         = FIELD_W'(px);
  assign hull_y         = FIELD_W'(py);
  assign last_vertex    = stat.vtx_last;
  assign points_dropped = overflow;
  assign walk_cut_short = stat.vtx_last && !closing;

  always_ff @(posedge clk) begin
    if (cmd.store && (count < CNT_W'(MAX_POINTS))) begin
      mem_x[count[IW-1:0]] <= point_x[KEEP-1:0];
      mem_y[count[IW-1:0]] <= point_y[KEEP-1:0];
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (cmd.finish) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (cmd.store) begin
      if (count < CNT_W'(MAX_POINTS)) begin
        count <= count + CNT_W'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      i <= '0;
    end
    if (cmd.scan_cmp) begin
      if ((i == '0) || (rd_x < sx) || ((rd_x == sx) && (rd_y < sy))) begin
        start <= i;
        sx    <= rd_x;
        sy    <= rd_y;
      end
      i <= i + IW'(1);
    end
    if (cmd.walk_init) begin
      p       <= start;
      px      <= sx;
      py      <= sy;
      emitted <= '0;
    end
    if (cmd.rd_q) begin
      q <= q0;
    end
    if (cmd.q_load) begin
      qx  <= rd_x;
      qy  <= rd_y;
      dqx <= DW'(rd_x) - DW'(px);
      dqy <= DW'(rd_y) - DW'(py);
      i   <= '0;
    end
    if (cmd.pt_diff) begin
      ix  <= rd_x;
      iy  <= rd_y;
      dix <= DW'(rd_x) - DW'(px);
      diy <= DW'(rd_y) - DW'(py);
    end
    if (cmd.pt_mul) begin
      prod_a <= PW'(dqy) * PW'(dix);
      prod_b <= PW'(diy) * PW'(dqx);
    end
    if (cmd.pt_cmp) begin
      if (prod_a < prod_b) begin
        q   <= i;
        qx  <= ix;
        qy  <= iy;
        dqx <= dix;
        dqy <= diy;
      end
      i <= i + IW'(1);
    end
    if (cmd.advance) begin
      p       <= q;
      px      <= qx;
      py      <= qy;
      emitted <= emitted + CNT_W'(1);
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for gift_wrapping_convex_hull: streams point sets with random gaps and stalls
// and checks every hull vertex against a gift-wrapping predictor held in this file.
// Depends on gwch_pkg and the gift_wrapping_convex_hull RTL.
module tb_top;
  import gwch_pkg::*;

  localparam int MAX_PTS      = MAX_POINTS_DEF;
  localparam int QUIET_TAIL   = 20;
  localparam int WATCH_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 4 * MAX_PTS + 40;
  localparam int RANDOM_ITEMS = 8;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic                      last;
    logic                      hold;
  } point_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic                      last_vertex;
    logic                      dropped;
    logic                      cut_short;
  } vertex_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      pt_valid = 1'b0;
  logic                      pt_stall;
  logic signed [FIELD_W-1:0] point_x = '0;
  logic signed [FIELD_W-1:0] point_y = '0;
  logic                      last_point = 1'b0;
  logic                      hull_valid;
  logic                      hull_stall = 1'b0;
  logic signed [FIELD_W-1:0] hull_x;
  logic signed [FIELD_W-1:0] hull_y;
  logic                      last_vertex;
  logic                      points_dropped;
  logic                      walk_cut_short;

  point_item_t pending[$];
  vertex_t     hull_expect[$];

  logic signed [FIELD_W-1:0] set_x [MAX_PTS];
  logic signed [FIELD_W-1:0] set_y [MAX_PTS];
  int                        set_count = 0;
  bit                        set_lost = 1'b0;

  bit failed = 1'b0;
  int send_gap;
  int stall_left;
  int quiet_cycles;

  gift_wrapping_convex_hull DUT (
    .clk           (clk),
    .rst           (rst),
    .pt_valid      (pt_valid),
    .pt_stall      (pt_stall),
    .point_x       (point_x),
    .point_y       (point_y),
    .last_point    (last_point),
    .hull_valid    (hull_valid),
    .hull_stall    (hull_stall),
    .hull_x        (hull_x),
    .hull_y        (hull_y),
    .last_vertex   (last_vertex),
    .points_dropped(points_dropped),
    .walk_cut_short(walk_cut_short)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit turns_clockwise(int p, int i, int q);
    longint dqx, dqy, dix, diy;
    dqx = longint'(set_x[q]) - longint'(set_x[p]);
    dqy = longint'(set_y[q]) - longint'(set_y[p]);
    dix = longint'(set_x[i]) - longint'(set_x[p]);
    diy = longint'(set_y[i]) - longint'(set_y[p]);
    return dqy * dix < diy * dqx;
  endfunction

  // Store one point; on the final point of a set walk the hull and queue its vertices.
  task automatic take_point(input logic signed [FIELD_W-1:0] x,
                            input logic signed [FIELD_W-1:0] y,
                            input logic last);
    int      start, p, q, emitted;
    bit      closed;
    vertex_t v;
    if (set_count < MAX_PTS) begin
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_count++;
    end else begin
      set_lost = 1'b1;
    end
    if (last) begin
      start = 0;
      for (int i = 1; i < set_count; i++) begin
        if (set_x[i] < set_x[start] || (set_x[i] == set_x[start] && set_y[i] < set_y[start]))
          start = i;
      end
      p = start;
      emitted = 0;
      closed = 1'b0;
      while (!closed && emitted < MAX_PTS) begin
        q = (p + 1) % set_count;
        for (int i = 0; i < set_count; i++) begin
          if (turns_clockwise(p, i, q))
            q = i;
        end
        emitted++;
        closed = (q == start);
        v.x = set_x[p];
        v.y = set_y[p];
        v.dropped = set_lost;
        v.last_vertex = closed || emitted == MAX_PTS;
        v.cut_short = !closed && emitted == MAX_PTS;
        hull_expect = {hull_expect, v};
        p = q;
      end
      set_count = 0;
      set_lost = 1'b0;
    end
  endtask

  task automatic add_point(input int x, input int y, input bit last, input bit hold);
    point_item_t it;
    it.x = FIELD_W'(x);
    it.y = FIELD_W'(y);
    it.last = last;
    it.hold = hold;
    pending = {pending, it};
  endtask

  // Span zero draws full-range coordinates; on_line puts every point on one line.
  task automatic add_random_set(input int size, input int span, input bit on_line,
                                input bit hold);
    int x, y, dx, dy, t;
    dx = int'($urandom_range(0, 6)) - 3;
    dy = int'($urandom_range(0, 6)) - 3;
    for (int k = 0; k < size; k++) begin
      if (on_line) begin
        t = int'($urandom_range(0, 20)) - 10;
        x = t * dx;
        y = t * dy + 7;
      end else if (span == 0) begin
        x = int'($urandom_range(0, 65535));
        y = int'($urandom_range(0, 65535));
      end else begin
        x = int'($urandom_range(0, 2 * span)) - span;
        y = int'($urandom_range(0, 2 * span)) - span;
      end
      add_point(x, y, k == size - 1, hold && k == 0);
    end
  endtask

  always @(posedge clk) begin : drive_points
    point_item_t nxt;
    logic        slot_free;
    if (rst) begin
      pt_valid <= 1'b0;
      point_x <= '0;
      point_y <= '0;
      last_point <= 1'b0;
      send_gap <= 0;
    end else begin
      slot_free = !pt_valid || !pt_stall;
      if (pt_valid && !pt_stall)
        take_point(point_x, point_y, last_point);
      if (slot_free) begin
        if (pending.size() > 0)
          nxt = pending[0];
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          pt_valid <= 1'b0;
        end else if (pending.size() > 0 && !(nxt.hold && hull_expect.size() > 0)) begin
          nxt = pending.pop_front();
          pt_valid <= 1'b1;
          point_x <= nxt.x;
          point_y <= nxt.y;
          last_point <= nxt.last;
          if (pending.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0)
            send_gap <= $urandom_range(1, 16);
        end else begin
          pt_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_hull
    vertex_t want;
    if (rst) begin
      hull_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (hull_valid && !hull_stall) begin
        if (hull_expect.size() == 0) begin
          $display("%0t: unexpected vertex (%0d, %0d), expected none", $time, hull_x, hull_y);
          failed = 1'b1;
        end else begin
          want = hull_expect.pop_front();
          if (hull_x !== want.x) begin
            $display("%0t: hull_x expected %0d, got %0d", $time, want.x, hull_x);
            failed = 1'b1;
          end
          if (hull_y !== want.y) begin
            $display("%0t: hull_y expected %0d, got %0d", $time, want.y, hull_y);
            failed = 1'b1;
          end
          if (last_vertex !== want.last_vertex) begin
            $display("%0t: last_vertex expected %0b, got %0b", $time, want.last_vertex,
                     last_vertex);
            failed = 1'b1;
          end
          if (points_dropped !== want.dropped) begin
            $display("%0t: points_dropped expected %0b, got %0b", $time, want.dropped,
                     points_dropped);
            failed = 1'b1;
          end
          if (walk_cut_short !== want.cut_short) begin
            $display("%0t: walk_cut_short expected %0b, got %0b", $time, want.cut_short,
                     walk_cut_short);
            failed = 1'b1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        hull_stall <= 1'b1;
      end else if (pending.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 15);
        hull_stall <= 1'b1;
      end else begin
        hull_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (pt_valid && !pt_stall) || (hull_valid && !hull_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int random_items, kind, size;

    // single point
    add_point(-32768, 32767, 1'b1, 1'b0);
    // coordinate extremes, leftmost tie broken by lowest y, start not at index 0
    add_point(32767, -32768, 1'b0, 1'b0);
    add_point(-32768, 32767, 1'b0, 1'b0);
    add_point(-32768, -32768, 1'b0, 1'b0);
    add_point(32767, 32767, 1'b0, 1'b0);
    add_point(0, 0, 1'b1, 1'b0);
    // duplicates
    add_point(5, 5, 1'b0, 1'b0);
    add_point(5, 5, 1'b0, 1'b0);
    add_point(5, 5, 1'b1, 1'b0);
    // collinear, out of order
    add_point(0, 0, 1'b0, 1'b0);
    add_point(3, 3, 1'b0, 1'b0);
    add_point(1, 1, 1'b0, 1'b0);
    add_point(2, 2, 1'b1, 1'b0);
    // vertical edge with a point on it
    add_point(-1, 4, 1'b0, 1'b0);
    add_point(-1, -4, 1'b0, 1'b0);
    add_point(-1, 0, 1'b0, 1'b0);
    add_point(6, 0, 1'b1, 1'b0);
    // square with interior point
    add_point(-1, -1, 1'b0, 1'b0);
    add_point(1, -1, 1'b0, 1'b0);
    add_point(1, 1, 1'b0, 1'b0);
    add_point(-1, 1, 1'b0, 1'b0);
    add_point(0, 0, 1'b1, 1'b0);

    // hold the first random set until the directed hulls drain
    add_random_set(6, 0, 1'b0, 1'b1);
    // fill the store, then drop the final point
    add_random_set(MAX_PTS + 1, 0, 1'b0, 1'b0);
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      size = $urandom_range(1, 10);
      case (kind)
        0, 1: begin
          size = $urandom_range(3, 14);
          add_random_set(size, 1, 1'b0, 1'b0);
        end
        2: add_random_set(size, 0, 1'b1, 1'b0);
        3, 4, 5: add_random_set(size, 0, 1'b0, 1'b0);
        default: add_random_set(size, 100, 1'b0, 1'b0);
      endcase
      random_items += size;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0 || pt_valid || hull_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/gwch_pkg.sv
hw/rtl/gwch_ctrl.sv
hw/rtl/gwch_dp.sv
hw/rtl/gift_wrapping_convex_hull.sv
tb/tb_top.sv
